// ===== rtl/olid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olid_pkg
// field widths, request and status codes shared by the ordered list core
// ----------------------------------------------------------------------------
package olid_pkg;

  // default list depth
  localparam int OLID_DEPTH = 32;

  // item field widths
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;

  // packed channel widths (tdata rounded up to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // request codes
  localparam logic [FUNC_W-1:0] FN_FRONT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POS     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_VAL = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_IDX = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADFUNC  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

endpackage
`default_nettype wire

// ===== rtl/olid_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olid_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module olid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ordered_list_insert_delete_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// ordered list of up to DEPTH words with insert, delete and read out
// ----------------------------------------------------------------------------
// one request item enters on the in_ channel; in_tuser carries the request
// code, in_tdata the word and the position. results leave on the out_ channel,
// out_tlast marks the final result of a request.
// the list lives in a single ram (one write, one registered read port); a
// small sequencer moves one entry per cycle through that port pair.
// steps per request, p = position:
//   insert        shift up from the tail, then write the word
//   delete value  one compaction pass over the whole list
//   delete index  shift down from p + 1
//   read out      one entry per cycle while out_tready is high
//   errors        a single status result
// the result register is loaded on the last of these steps.
// in_tready is high only while the sequencer is idle; a finished result may
// still sit in the output register, so the next request is taken meanwhile.
// a stalled receiver holds the read out at the current entry, nothing lost.
// reset empties the list (count to zero); ram contents are not cleared since
// entries at or beyond the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core #(
  parameter int DEPTH = olid_pkg::OLID_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [olid_pkg::IN_TDATA_W-1:0]  in_tdata,  // item_value, position, zero fill
  input  wire logic [olid_pkg::FUNC_W-1:0]      in_tuser,  // func
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [olid_pkg::OUT_TDATA_W-1:0] out_tdata, // entry_data, entry_index,
                                                           // list_count, zero fill
  output logic      [olid_pkg::STATUS_W-1:0]    out_tuser, // status
  output logic                                  out_tlast  // last
);

  import olid_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // working width for cursors and position compares
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_MV,
    S_INS_WR,
    S_DV,
    S_DV_END,
    S_DI_MV,
    S_DI_END,
    S_RO,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CMP_W-1:0]      cur_r, cur_nxt;       // shift / read cursor
  logic [CMP_W-1:0]      wr_r, wr_nxt;         // compaction write pointer
  logic [CMP_W-1:0]      pos_r, pos_nxt;       // insert position
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic [INDEX_W-1:0]    out_index_r, out_index_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  // ram port
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [VALUE_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [VALUE_W-1:0]    mem_rdata;

  // request fields
  logic [FUNC_W-1:0]     in_func;
  logic [VALUE_W-1:0]    in_value;
  logic [POS_W-1:0]      in_pos;
  logic                  in_fire;

  logic                  out_free;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      in_pos_ext;
  logic [CMP_W-1:0]      ins_pos;
  logic [CMP_W-1:0]      cur_m1, cur_m2, cur_p1, cur_p2, pos_p1;

  assign in_func  = in_tuser;
  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_pos   = in_tdata[VALUE_W+POS_W-1:VALUE_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // output register can take a new result this cycle
  assign out_free  = !out_valid_r || out_tready;

  assign cnt_ext    = CMP_W'(count_r);
  assign in_pos_ext = CMP_W'(in_pos);
  assign cur_m1     = cur_r - CMP_W'(1);
  assign cur_m2     = cur_r - CMP_W'(2);
  assign cur_p1     = cur_r + CMP_W'(1);
  assign cur_p2     = cur_r + CMP_W'(2);
  assign pos_p1     = in_pos_ext + CMP_W'(1);

  olid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    wr_nxt         = wr_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    ins_pos        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt    = in_value;
          status_nxt = ST_OK;
          unique case (in_func) inside
            FN_FRONT, FN_POS, FN_APPEND: begin
              if (in_func == FN_FRONT) begin
                ins_pos = '0;
              end else if (in_func == FN_APPEND) begin
                ins_pos = cnt_ext;
              end else begin
                ins_pos = in_pos_ext;
              end
              pos_nxt = ins_pos;
              cur_nxt = cnt_ext;
              // bad position reported before full
              if (ins_pos > cnt_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (cnt_ext >= CMP_W'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if (cnt_ext > ins_pos) begin
                // fetch the tail entry to move up one place
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(cnt_ext - CMP_W'(1));
                state_nxt = S_INS_MV;
              end else begin
                state_nxt = S_INS_WR;
              end
            end
            FN_DEL_VAL: begin
              if (count_r == '0) begin
                status_nxt = ST_NOTFOUND;
                state_nxt  = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                cur_nxt   = CMP_W'(1);
                wr_nxt    = '0;
                state_nxt = S_DV;
              end
            end
            FN_DEL_IDX: begin
              cur_nxt = in_pos_ext;
              if (in_pos_ext >= cnt_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (pos_p1 < cnt_ext) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(pos_p1);
                state_nxt = S_DI_MV;
              end else begin
                // last entry removed, nothing to shift
                state_nxt = S_DI_END;
              end
            end
            FN_READ: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                cur_nxt   = '0;
                state_nxt = S_RO;
              end
            end
            default: begin
              status_nxt = ST_BADFUNC;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      // move entry cur-1 up to cur, prefetching cur-2
      S_INS_MV: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cur_r);
        mem_wdata = mem_rdata;
        cur_nxt   = cur_m1;
        if (cur_m1 > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(cur_m2);
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(pos_r);
        mem_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      // compaction: keep entries that differ, read runs ahead of write
      S_DV: begin
        if (mem_rdata != val_r) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(wr_r);
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + CMP_W'(1);
        end
        if (cur_r < cnt_ext) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(cur_r);
          cur_nxt   = cur_p1;
        end else begin
          state_nxt = S_DV_END;
        end
      end

      S_DV_END: begin
        status_nxt = (wr_r == cnt_ext) ? ST_NOTFOUND : ST_OK;
        count_nxt  = CNT_W'(wr_r);
        state_nxt  = S_RESP;
      end

      // move entry cur+1 down to cur, prefetching cur+2
      S_DI_MV: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cur_r);
        mem_wdata = mem_rdata;
        cur_nxt   = cur_p1;
        if (cur_p2 < cnt_ext) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(cur_p2);
        end else begin
          state_nxt = S_DI_END;
        end
      end

      S_DI_END: begin
        count_nxt = count_r - CNT_W'(1);
        state_nxt = S_RESP;
      end

      // read out, one entry per free output slot; ram data holds on stall
      S_RO: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = mem_rdata;
          out_index_nxt  = cur_r[INDEX_W-1:0];
          out_count_nxt  = cnt_ext[COUNT_W-1:0];
          out_status_nxt = ST_OK;
          out_last_nxt   = (cur_p1 == cnt_ext);
          if (cur_p1 == cnt_ext) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(cur_p1);
            cur_nxt   = cur_p1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_index_nxt  = '0;
          out_count_nxt  = cnt_ext[COUNT_W-1:0];
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    wr_r         <= wr_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - VALUE_W - INDEX_W - COUNT_W){1'b0}},
                       out_count_r, out_index_r, out_data_r};

  // the list never holds more than DEPTH entries
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  // an accepted request always moves the sequencer out of idle in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted without leaving idle");

  // the sequencer never writes the list while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("list written while idle");

  // the count changes only on the way to the single-result response
  a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
    (count_nxt != count_r) |=> (state_r == S_RESP))
    else $error("entry count changed outside an update step");

endmodule
`default_nettype wire
